>>> rtl/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
`default_nettype none

package wsfd_pkg;

   // Result kinds, carried on rsp_tuser
   localparam logic [1:0] KIND_TEXT  = 2'd0;
   localparam logic [1:0] KIND_OTHER = 2'd1;
   localparam logic [1:0] KIND_CLOSE = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   // Protocol error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_FIN      = 3'd1;
   localparam logic [2:0] ERR_MASK     = 3'd2;
   localparam logic [2:0] ERR_LEN64    = 3'd3;
   localparam logic [2:0] ERR_TOO_LONG = 3'd4;

   // Frame opcodes of interest
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_CLOSE = 4'h8;

   // 7-bit length codes that select the extended forms
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd4096;

   // One result from the parser
   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic [7:0] payload_byte;
      logic       last_byte;
      logic [2:0] error_code;
      logic [3:0] frame_opcode;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/wsfd_parser.sv
// Frame header parser, mask key store, payload unmasking; one byte per cycle on step.
`default_nettype none

module wsfd_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,          // process data_byte this cycle
   input  wire logic [7:0]          data_byte,
   input  wire logic [15:0]         max_payload,
   output wsfd_pkg::result_type     result
);
   import wsfd_pkg::*;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT,
      PH_MASK,
      PH_DATA
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic [15:0] length_ff, length_in;
   logic [31:0] mask_ff, mask_in;
   logic [15:0] count_ff, count_in;
   logic [1:0]  hidx_ff, hidx_in;
   logic        halted_ff, halted_in;

   logic [15:0] length_sel;
   logic        too_long;
   logic [7:0]  key_byte;
   logic [16:0] count_next;
   logic        last;

   // Length that completes in this byte, and the limit check
   assign length_sel = (phase_ff == PH_HDR1) ? {9'd0, data_byte[6:0]}
                                             : {length_ff[7:0], data_byte};
   assign too_long   = length_sel > max_payload;

   // Unmask path
   assign key_byte   = mask_ff[{count_ff[1:0], 3'b000} +: 8];
   assign count_next = {1'b0, count_ff} + 17'd1;
   assign last       = count_next >= {1'b0, length_ff};

   // Next state and result
   always_comb begin
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      length_in = length_ff;
      mask_in   = mask_ff;
      count_in  = count_ff;
      hidx_in   = hidx_ff;
      halted_in = halted_ff;
      result    = '0;
      result.frame_opcode = opcode_ff;

      if (!halted_ff) begin
         case (phase_ff)
            PH_HDR0: begin
               opcode_in = data_byte[3:0];
               result.frame_opcode = data_byte[3:0];
               if (!data_byte[7]) begin
                  halted_in         = 1'b1;
                  result.valid      = 1'b1;
                  result.kind       = KIND_ERROR;
                  result.error_code = ERR_FIN;
               end else begin
                  phase_in = PH_HDR1;
               end
            end
            PH_HDR1: begin
               if (!data_byte[7]) begin
                  halted_in         = 1'b1;
                  result.valid      = 1'b1;
                  result.kind       = KIND_ERROR;
                  result.error_code = ERR_MASK;
               end else if (data_byte[6:0] == LEN_EXT64) begin
                  halted_in         = 1'b1;
                  result.valid      = 1'b1;
                  result.kind       = KIND_ERROR;
                  result.error_code = ERR_LEN64;
               end else if (data_byte[6:0] == LEN_EXT16) begin
                  phase_in  = PH_EXT;
                  hidx_in   = 2'd0;
                  length_in = '0;
               end else begin
                  length_in = length_sel;
                  if (too_long) begin
                     halted_in         = 1'b1;
                     result.valid      = 1'b1;
                     result.kind       = KIND_ERROR;
                     result.error_code = ERR_TOO_LONG;
                  end else begin
                     phase_in = PH_MASK;
                     hidx_in  = 2'd0;
                     mask_in  = '0;
                  end
               end
            end
            PH_EXT: begin
               length_in = length_sel;
               if (hidx_ff == 2'd0) begin
                  hidx_in = 2'd1;
               end else if (too_long) begin
                  halted_in         = 1'b1;
                  result.valid      = 1'b1;
                  result.kind       = KIND_ERROR;
                  result.error_code = ERR_TOO_LONG;
               end else begin
                  phase_in = PH_MASK;
                  hidx_in  = 2'd0;
                  mask_in  = '0;
               end
            end
            PH_MASK: begin
               mask_in[{hidx_ff, 3'b000} +: 8] = data_byte;
               if (hidx_ff != 2'd3) begin
                  hidx_in = hidx_ff + 2'd1;
               end else begin
                  hidx_in  = 2'd0;
                  count_in = '0;
                  if (length_ff == 16'd0) begin
                     // empty frame ends right after its key
                     phase_in     = PH_HDR0;
                     result.valid = 1'b1;
                     if (opcode_ff == OP_CLOSE) begin
                        halted_in   = 1'b1;
                        result.kind = KIND_CLOSE;
                     end else begin
                        result.kind = KIND_OTHER;
                     end
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               count_in = count_next[15:0];
               if (opcode_ff == OP_TEXT) begin
                  if (last) begin
                     phase_in = PH_HDR0;
                  end
                  result.valid        = 1'b1;
                  result.kind         = KIND_TEXT;
                  result.payload_byte = data_byte ^ key_byte;
                  result.last_byte    = last;
               end else if (last) begin
                  phase_in     = PH_HDR0;
                  result.valid = 1'b1;
                  if (opcode_ff == OP_CLOSE) begin
                     halted_in   = 1'b1;
                     result.kind = KIND_CLOSE;
                  end else begin
                     result.kind = KIND_OTHER;
                  end
               end
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase
      end
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         opcode_ff <= '0;
         length_ff <= '0;
         mask_ff   <= '0;
         count_ff  <= '0;
         hidx_ff   <= '0;
         halted_ff <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         length_ff <= length_in;
         mask_ff   <= mask_in;
         count_ff  <= count_in;
         hidx_ff   <= hidx_in;
         halted_ff <= halted_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/websocket_frame_deframer.sv
// Top level of the WebSocket client frame deframer: input register, parser, result register.
//
// Usage:
//   req_* carries the client byte stream, one byte per transaction in req_tdata.
//   rsp_* carries at most one result per input byte: kind on rsp_tuser, last
//   payload byte of a text frame on rsp_tlast, payload byte, error code and
//   frame opcode in rsp_tdata. Unmasked bytes of non-empty text frames come
//   out; other frames give one result at their end.
//   csr_wr_en / csr_wr_data write the payload length limit (reset 4096);
//   write it only while no bytes are in flight.
// Timing:
//   A byte is registered in the input register when it is accepted and runs
//   through the parser when the parser advances; any result lands in the
//   result register then and is shown on rsp_* until taken. One byte per
//   cycle is sustained while rsp_tready stays high; the input register lets
//   one more byte enter while a result waits.
// Reset clears the parser to await a frame header and empties both
// registers. A close frame or a protocol error halts the parser until reset.
// When rsp_tready is low the result holds, the input register fills, and
// req_tready drops until the result is taken.
`default_nettype none

module websocket_frame_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   // input stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] data_byte
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,    // [7:0] payload_byte, [10:8] error_code,
                                          // [14:11] frame_opcode_out, [15] zero
   output logic [1:0]       rsp_tuser,    // [1:0] kind
   output logic             rsp_tlast,    // last_byte
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data   // max_payload
);
   import wsfd_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_data_ff;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff;
   logic [15:0] max_payload_ff;
   logic        advance;
   result_type  result;

   // Parser advances when a byte waits and the result register can take a result
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   wsfd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .data_byte   (in_data_ff),
      .max_payload (max_payload_ff),
      .result      (result)
   );

   // Input register
   always_comb begin
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Result register
   always_comb begin
      if (advance && result.valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            max_payload_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
      end
      if (advance && result.valid) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.frame_opcode, out_ff.error_code, out_ff.payload_byte};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last_byte;

endmodule

`default_nettype wire

>>> rtl/wsfd_checker.sv
// Port-level assertions for the deframer, bound to the top level.
`default_nettype none

module wsfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   import wsfd_pkg::*;

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending right after reset");

   // A stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // After a close or an error is taken, the block is halted and stays silent
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && (rsp_tuser == KIND_CLOSE || rsp_tuser == KIND_ERROR)
         |=> !rsp_tvalid)
      else $error("result after close or error");

   // Last flag only on text payload bytes, and text bytes carry no error code
   a_last_text: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tlast || rsp_tuser == KIND_TEXT) |->
         rsp_tuser == KIND_TEXT && rsp_tdata[10:8] == ERR_NONE)
      else $error("last flag or error code on wrong kind");

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the WebSocket client frame deframer.

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wsfd_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction on either side
   localparam int DRAIN_CYCLES   = 4;     // covers the two-stage pipeline
   localparam int TAIL_CYCLES    = 8;

   typedef enum logic [2:0] {
      AWAIT_HDR0, AWAIT_HDR1, EXT_LEN, MASK_KEY, PAYLOAD
   } parse_phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] payload;
      logic       is_last;
      logic [2:0] err;
      logic [3:0] opcode;
   } deframe_result_type;

   // Parser state mirror plus the queue of results still owed by the block
   class frame_scoreboard;
      logic [15:0]        max_payload;
      parse_phase_type    phase;
      logic [3:0]         opcode;
      logic [15:0]        pay_len;
      logic [31:0]        mask_key;
      logic [15:0]        byte_cnt;
      logic [1:0]         hdr_idx;
      bit                 halted;
      deframe_result_type expected_results[$];
      int                 errors;

      function new();
         max_payload = MAX_PAYLOAD_RESET;
         phase       = AWAIT_HDR0;
         opcode      = '0;
         pay_len     = '0;
         mask_key    = '0;
         byte_cnt    = '0;
         hdr_idx     = '0;
         halted      = 1'b0;
         errors      = 0;
      endfunction

      function void set_limit(logic [15:0] value);
         max_payload = value;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void owe(logic [1:0] kind, logic [7:0] pb, logic is_last, logic [2:0] err);
         deframe_result_type r;
         r.kind    = kind;
         r.payload = pb;
         r.is_last = is_last;
         r.err     = err;
         r.opcode  = opcode;
         expected_results.push_back(r);
      endfunction

      function void protocol_error(logic [2:0] err);
         halted = 1'b1;
         owe(KIND_ERROR, 8'h00, 1'b0, err);
      endfunction

      // Non-text or empty frame finished; a close frame stops the parser
      function void frame_done();
         phase = AWAIT_HDR0;
         if (opcode == OP_CLOSE) begin
            halted = 1'b1;
            owe(KIND_CLOSE, 8'h00, 1'b0, ERR_NONE);
         end else begin
            owe(KIND_OTHER, 8'h00, 1'b0, ERR_NONE);
         end
      endfunction

      function void length_done();
         if (pay_len > max_payload) begin
            protocol_error(ERR_TOO_LONG);
         end else begin
            phase    = MASK_KEY;
            hdr_idx  = '0;
            mask_key = '0;
         end
      endfunction

      // Advance the mirror by one accepted byte
      function void note_byte(logic [7:0] b);
         logic [7:0] plain;
         logic       is_last;
         if (halted) return;
         case (phase)
            AWAIT_HDR0: begin
               opcode = b[3:0];
               if (!b[7]) protocol_error(ERR_FIN);
               else phase = AWAIT_HDR1;
            end
            AWAIT_HDR1: begin
               if (!b[7]) protocol_error(ERR_MASK);
               else if (b[6:0] == LEN_EXT64) protocol_error(ERR_LEN64);
               else if (b[6:0] == LEN_EXT16) begin
                  phase   = EXT_LEN;
                  hdr_idx = '0;
                  pay_len = '0;
               end else begin
                  pay_len = {9'd0, b[6:0]};
                  length_done();
               end
            end
            EXT_LEN: begin
               pay_len = {pay_len[7:0], b};
               if (hdr_idx == 2'd0) hdr_idx = 2'd1;
               else length_done();
            end
            MASK_KEY: begin
               mask_key[8*hdr_idx +: 8] = b;
               if (hdr_idx < 2'd3) begin
                  hdr_idx = hdr_idx + 2'd1;
               end else begin
                  hdr_idx  = '0;
                  byte_cnt = '0;
                  if (pay_len == 16'd0) frame_done();
                  else phase = PAYLOAD;
               end
            end
            PAYLOAD: begin
               plain    = b ^ mask_key[8*byte_cnt[1:0] +: 8];
               is_last  = ({1'b0, byte_cnt} + 17'd1) >= {1'b0, pay_len};
               byte_cnt = byte_cnt + 16'd1;
               if (opcode == OP_TEXT) begin
                  if (is_last) phase = AWAIT_HDR0;
                  owe(KIND_TEXT, plain, is_last, ERR_NONE);
               end else if (is_last) begin
                  frame_done();
               end
            end
            default: phase = AWAIT_HDR0;
         endcase
      endfunction

      function void compare_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
         if (act_val !== exp_val) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
         end
      endfunction

      function void check_result(logic [1:0] kind, logic [15:0] data, logic is_last);
         deframe_result_type r;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual kind %0d data %0h last %0b",
                     $time, kind, data, is_last);
            return;
         end
         r = expected_results.pop_front();
         compare_field("kind", r.kind, kind);
         compare_field("payload_byte", r.payload, data[7:0]);
         compare_field("last_byte", r.is_last, is_last);
         compare_field("error_code", r.err, data[10:8]);
         compare_field("frame_opcode", r.opcode, data[14:11]);
         compare_field("tdata pad", 16'd0, data[15]);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'h0000;

   frame_scoreboard sb;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int unsigned bytes_sent = 0;
   int          quiet_cycles = 0;

   websocket_frame_deframer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Monitor both channels on the rising edge
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_byte(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Watchdog: no transaction for too long ends the run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending());
            $display("FAILURE");
            $finish;
         end
      end
   end

   // One byte transaction; entered and left just after a falling edge
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Stop sending and wait until every owed result has been taken
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic configure_limit(input logic [15:0] value);
      quiesce();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_limit(value);
   endtask

   // Well-formed masked frame with random reserved bits, key and payload
   task automatic send_frame(input logic [3:0] op, input int unsigned len, input bit ext);
      logic [31:0] key;
      logic [15:0] len16;
      len16 = 16'(len);
      key   = $urandom;
      send_byte({1'b1, 3'($urandom_range(0, 7)), op});
      if (ext || len > 125) begin
         send_byte({1'b1, LEN_EXT16});
         send_byte(len16[15:8]);
         send_byte(len16[7:0]);
      end else begin
         send_byte({1'b1, len16[6:0]});
      end
      for (int i = 0; i < 4; i++) send_byte(key[8*i +: 8]);
      for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom));
   endtask

   // Random frames within the current limit, mostly text and mostly short
   task automatic random_frames(input int unsigned n_bytes);
      int unsigned start;
      int unsigned cap;
      logic [3:0]  op;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         if ($urandom_range(0, 99) < 70) begin
            op = OP_TEXT;
         end else begin
            do op = 4'($urandom); while (op == OP_CLOSE);
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: cap = 20;
            6, 7:             cap = 125;
            default:          cap = 300;
         endcase
         if (cap > sb.max_payload) cap = sb.max_payload;
         send_frame(op, $urandom_range(0, cap), $urandom_range(0, 6) == 0);
      end
   endtask

   // Every halting case ends the run; the seed picks which one, then noise follows
   task automatic finish_with_halt();
      int unsigned lim;
      logic [15:0] len16;
      case ($urandom_range(0, 4))
         0: send_byte({1'b0, 7'($urandom)});                 // FIN clear
         1: begin                                            // MASK clear
            send_byte({1'b1, 7'($urandom)});
            send_byte({1'b0, 7'($urandom)});
         end
         2: begin                                            // 64-bit length
            send_byte({1'b1, 7'($urandom)});
            send_byte({1'b1, LEN_EXT64});
         end
         3: begin                                            // longer than the limit
            lim = $urandom_range(0, 65534);
            configure_limit(16'(lim));
            send_byte({1'b1, 7'($urandom)});
            if (lim < 125 && $urandom_range(0, 1) == 1) begin
               send_byte({1'b1, 7'($urandom_range(lim + 1, 125))});
            end else begin
               len16 = 16'($urandom_range(lim + 1, 65535));
               send_byte({1'b1, LEN_EXT16});
               send_byte(len16[15:8]);
               send_byte(len16[7:0]);
            end
         end
         default: send_frame(OP_CLOSE, $urandom_range(0, 10), $urandom_range(0, 1) == 1);
      endcase
      // halted parser must ignore everything from here on
      repeat (12) send_byte(8'($urandom));
   endtask

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 9;
      recv_idle_pct = 45;

      // Directed: empty text frame, short non-text frame, limit changed mid-frame
      send_frame(OP_TEXT, 0, 1'b0);
      send_byte(8'hF2);
      send_byte(8'h81);
      send_byte(8'hFF); send_byte(8'h00); send_byte(8'h80); send_byte(8'h7F);
      send_byte(8'h5A);
      send_byte(8'h81);
      configure_limit(16'd3);
      send_byte(8'h83);                                      // length equals the limit
      send_byte(8'hFF); send_byte(8'h00); send_byte(8'h80); send_byte(8'h7F);
      send_byte(8'hFF); send_byte(8'h00); send_byte(8'h01);

      configure_limit(16'hFFFF);
      random_frames(330);

      // Zero limit: only empty frames are legal
      configure_limit(16'd0);
      send_frame(OP_TEXT, 0, 1'b0);
      send_frame(4'h2, 0, 1'b1);
      send_frame(4'h9, 0, 1'b0);

      send_idle_pct = 45;
      recv_idle_pct = 9;
      configure_limit(16'($urandom_range(50, 1000)));
      random_frames(330);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure_limit(16'($urandom_range(16, 65535)));
      random_frames(330);

      finish_with_halt();
      quiesce();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (sb.pending() != 0)
         $display("%0t: %0d expected results never arrived", $time, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
